// ----- rtl/u16emo_pkg.sv -----
package u16emo_pkg;

   localparam int UnitWidth = 16;
   localparam int LeadWidth = 10;
   localparam int CpWidth   = 21;

   localparam logic [5:0] LeadTag  = 6'b110110;
   localparam logic [5:0] TrailTag = 6'b110111;

   localparam logic [CpWidth-1:0] SuppBase = 21'h10000;

   localparam logic [CpWidth-1:0] VarSel16   = 21'h0FE0F;
   localparam logic [CpWidth-1:0] VarSel15   = 21'h0FE0E;
   localparam logic [CpWidth-1:0] Zwj        = 21'h0200D;
   localparam logic [CpWidth-1:0] SkinLo     = 21'h1F3FB;
   localparam logic [CpWidth-1:0] SkinHi     = 21'h1F3FF;

   typedef struct packed {
      logic is_nul;
      logic starter;
      logic component;
   } cp_class_type;

endpackage

// ----- rtl/utf16_emoji_text_classifier.sv -----
// A code unit accepted into the input stage is scanned there; for the last
//   unit of a string the result word is registered in the output stage.
// Throughput: one code unit per cycle, set by the single scan stage, unless
//   a last unit stalls on a held result. Reset (synchronous, active high)
//   empties both stages and clears the pending lead, flags and stop state.
module utf16_emoji_text_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_starter,
   output logic        rsp_emoji_only
);
   import u16emo_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [UnitWidth-1:0] s1_unit_ff;
   logic                 s1_last_ff;
   logic                 s1_go;
   logic                 req_take;

   logic                 lead_pending_ff, lead_pending_in;
   logic [LeadWidth-1:0] lead_bits_ff, lead_bits_in;
   logic                 seen_emoji_ff, seen_emoji_in;
   logic                 seen_starter_ff, seen_starter_in;
   logic                 rejected_ff, rejected_in;
   logic                 stopped_ff, stopped_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_has_starter_ff, rsp_has_starter_in;
   logic                 rsp_emoji_only_ff, rsp_emoji_only_in;

   logic                 is_lead, is_trail, pair, take, lead_rej;
   logic [CpWidth-1:0]   cp;
   cp_class_type         cls;
   logic                 starter_new, emoji_new, rej_new, stop_new;

   // input stage
   assign s1_go     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_unit_ff <= req_code_unit;
         s1_last_ff <= req_last_unit;
      end
   end

   // surrogate join
   assign is_lead  = (s1_unit_ff[15:10] == LeadTag);
   assign is_trail = (s1_unit_ff[15:10] == TrailTag);
   assign pair     = lead_pending_ff && is_trail;
   assign cp       = pair ? ({1'b0, lead_bits_ff, s1_unit_ff[9:0]} + SuppBase)
                          : {{(CpWidth-UnitWidth){1'b0}}, s1_unit_ff};

   u16emo_cp_class u_cls (
      .cp  (cp),
      .cls (cls)
   );

   // an unpaired lead before any NUL is a surrogate code point and rejects
   assign take     = !stopped_ff && (pair || !is_lead);
   assign lead_rej = !stopped_ff && !pair && (lead_pending_ff || (is_lead && s1_last_ff));

   assign stop_new    = take && cls.is_nul;
   assign starter_new = take && cls.starter;
   assign emoji_new   = take && cls.starter && !cls.component;
   assign rej_new     = lead_rej ||
                        (take && !cls.is_nul && !cls.component && !cls.starter);

   always_comb begin
      lead_pending_in    = lead_pending_ff;
      lead_bits_in       = lead_bits_ff;
      seen_emoji_in      = seen_emoji_ff;
      seen_starter_in    = seen_starter_ff;
      rejected_in        = rejected_ff;
      stopped_in         = stopped_ff;
      rsp_has_starter_in = rsp_has_starter_ff;
      rsp_emoji_only_in  = rsp_emoji_only_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (s1_go) begin
         if (s1_last_ff) begin
            rsp_valid_in       = 1'b1;
            rsp_has_starter_in = seen_starter_ff || starter_new;
            rsp_emoji_only_in  = (seen_emoji_ff || emoji_new) && !(rejected_ff || rej_new);
            lead_pending_in    = 1'b0;
            lead_bits_in       = '0;
            seen_emoji_in      = 1'b0;
            seen_starter_in    = 1'b0;
            rejected_in        = 1'b0;
            stopped_in         = 1'b0;
         end else begin
            lead_pending_in = !stopped_ff && !pair && is_lead;
            if (!stopped_ff && !pair && is_lead) begin
               lead_bits_in = s1_unit_ff[9:0];
            end
            seen_emoji_in   = seen_emoji_ff || emoji_new;
            seen_starter_in = seen_starter_ff || starter_new;
            rejected_in     = rejected_ff || rej_new;
            stopped_in      = stopped_ff || stop_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_bits_ff    <= '0;
         seen_emoji_ff   <= 1'b0;
         seen_starter_ff <= 1'b0;
         rejected_ff     <= 1'b0;
         stopped_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_bits_ff    <= lead_bits_in;
         seen_emoji_ff   <= seen_emoji_in;
         seen_starter_ff <= seen_starter_in;
         rejected_ff     <= rejected_in;
         stopped_ff      <= stopped_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_has_starter_ff <= rsp_has_starter_in;
      rsp_emoji_only_ff  <= rsp_emoji_only_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_starter = rsp_has_starter_ff;
   assign rsp_emoji_only  = rsp_emoji_only_ff;

   // a pending lead is always flushed before a NUL can stop the scan
   a_no_lead_when_stopped: assert property (@(posedge clock) disable iff (reset)
      !(lead_pending_ff && stopped_ff))
      else $error("lead pending while stopped");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (!lead_pending_ff && !seen_emoji_ff &&
                                 !seen_starter_ff && !rejected_ff && !stopped_ff))
      else $error("state not cleared after last unit");

   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> rsp_valid_ff)
      else $error("last unit gave no result word");

   a_only_needs_starter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_emoji_only_ff) |-> rsp_has_starter_ff)
      else $error("emoji_only without starter");

   a_seen_needs_starter: assert property (@(posedge clock) disable iff (reset)
      seen_emoji_ff |-> seen_starter_ff)
      else $error("emoji seen without starter");

endmodule

// ----- rtl/u16emo_cp_class.sv -----
module u16emo_cp_class (
   input  logic [u16emo_pkg::CpWidth-1:0] cp,
   output u16emo_pkg::cp_class_type       cls
);
   import u16emo_pkg::*;

   function automatic logic in_rng(logic [CpWidth-1:0] v, logic [CpWidth-1:0] lo,
                                   logic [CpWidth-1:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   always_comb begin
      cls.is_nul    = (cp == '0);
      cls.starter   = in_rng(cp, 21'h1F300, 21'h1F5FF) ||
                      in_rng(cp, 21'h1F600, 21'h1F64F) ||
                      in_rng(cp, 21'h1F680, 21'h1F6FF) ||
                      in_rng(cp, 21'h1F700, 21'h1F77F) ||
                      in_rng(cp, 21'h1F900, 21'h1F9FF) ||
                      in_rng(cp, 21'h1FA70, 21'h1FAFF) ||
                      in_rng(cp, 21'h02600, 21'h027BF) ||
                      in_rng(cp, 21'h1F1E6, 21'h1F1FF);
      cls.component = (cp == VarSel16) || (cp == VarSel15) || (cp == Zwj) ||
                      in_rng(cp, SkinLo, SkinHi);
   end

endmodule
